>>> hdl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int CNT_W     = 17;
    localparam int ADDR_W    = 48;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 1'b1;

    localparam logic [CFG_W-1:0] PAGE_LIMIT_RST     = 17'd65536;
    localparam logic [CFG_W-1:0] RESERVED_PAGES_RST = 17'd3840;

    localparam logic [ADDR_W-1:0] BASE_ADDR = 48'h0000_0100_0000;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_FULL   = 2'd1,
        RES_RANGE  = 2'd2,
        RES_DOUBLE = 2'd3
    } res_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] page_address;
    } in_item_t;

    typedef struct packed {
        logic              ok;
        res_t              status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  free_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_INIT,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic rd;         // read the current bitmap word
        logic step;       // advance the search to the next word
        logic latch_hit;  // keep the page found in the current word
        logic wr;         // write back the updated bitmap word
        logic fill;       // write one word of the clear / init sweep
        logic finish;     // load the result register and commit counters
        res_t res;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  t_zero;
        logic  in_range;
        logic  hit;
        logic  exhausted;
        logic  fill_last;
        logic  out_full;
    } dp_status_t;

endpackage

>>> hdl/bpfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bpfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer of the allocator: clearing pass, search, free and init sweep.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  bpfa_pkg::kind_t       in_kind,
    output logic                  s_ready,
    output bpfa_pkg::dp_cmd_t     cmd,
    input  bpfa_pkg::dp_status_t  status
);

    bpfa_pkg::ctrl_state_t state_reg, state_next;
    bpfa_pkg::res_t        res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpfa_pkg::ST_CLEAR;
            res_reg   <= bpfa_pkg::RES_OK;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        s_ready    = 1'b0;
        case (state_reg)
            bpfa_pkg::ST_CLEAR: begin
                cmd.fill = 1'b1;
                if (status.fill_last) begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    res_next = bpfa_pkg::RES_OK;
                    case (in_kind)
                        bpfa_pkg::KIND_ALLOC: state_next = bpfa_pkg::ST_READ;
                        bpfa_pkg::KIND_FREE:  state_next = bpfa_pkg::ST_READ;
                        bpfa_pkg::KIND_INIT:  state_next = bpfa_pkg::ST_INIT;
                        default:              state_next = bpfa_pkg::ST_DONE;
                    endcase
                end
            end
            bpfa_pkg::ST_READ: begin
                if (status.kind == bpfa_pkg::KIND_ALLOC && status.t_zero) begin
                    res_next   = bpfa_pkg::RES_FULL;
                    state_next = bpfa_pkg::ST_DONE;
                end else if (status.kind == bpfa_pkg::KIND_FREE && !status.in_range) begin
                    res_next   = bpfa_pkg::RES_RANGE;
                    state_next = bpfa_pkg::ST_DONE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = bpfa_pkg::ST_CHECK;
                end
            end
            bpfa_pkg::ST_CHECK: begin
                if (status.hit) begin
                    cmd.latch_hit = 1'b1;
                    state_next    = bpfa_pkg::ST_WRITE;
                end else if (status.kind == bpfa_pkg::KIND_FREE) begin
                    res_next   = bpfa_pkg::RES_DOUBLE;
                    state_next = bpfa_pkg::ST_DONE;
                end else if (status.exhausted) begin
                    res_next   = bpfa_pkg::RES_FULL;
                    state_next = bpfa_pkg::ST_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = bpfa_pkg::ST_READ;
                end
            end
            bpfa_pkg::ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = bpfa_pkg::ST_DONE;
            end
            bpfa_pkg::ST_INIT: begin
                cmd.fill = 1'b1;
                if (status.fill_last) begin
                    state_next = bpfa_pkg::ST_DONE;
                end
            end
            bpfa_pkg::ST_DONE: begin
                if (!status.out_full) begin
                    cmd.finish = 1'b1;
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_finish_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !status.out_full)
        else $error("result committed while output register still full");

    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bpfa_pkg::ST_CHECK |-> $past(state_reg) == bpfa_pkg::ST_READ)
        else $error("bitmap word checked without a read");

    a_write_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bpfa_pkg::ST_WRITE |-> $past(status.hit))
        else $error("bitmap write-back without a hit");
`endif

endmodule

>>> hdl/bpfa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_dpath
// Bitmap store, word search, page counters and result register.
// ----------------------------------------------------------------------------
module bpfa_dpath #(
    parameter int MAX_PAGES  = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bpfa_pkg::dp_cmd_t              cmd,
    output bpfa_pkg::dp_status_t           status,
    input  bpfa_pkg::in_item_t             in_item,
    input  logic [bpfa_pkg::CFG_W-1:0]     page_limit,
    input  logic [bpfa_pkg::CFG_W-1:0]     reserved_pages,
    input  logic                           m_ready,
    output logic                           m_valid,
    output bpfa_pkg::out_item_t            m_payload
);

    localparam int WB     = (MAX_PAGES < 64) ? 4 : 32;
    localparam int WBL    = $clog2(WB);
    localparam int NWORDS = (MAX_PAGES + WB - 1) / WB;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IW     = $clog2(MAX_PAGES);
    localparam int PBL    = $clog2(PAGE_BYTES);
    localparam int CW     = bpfa_pkg::CNT_W;
    localparam int XW     = bpfa_pkg::ADDR_W;

    // control state
    logic [AW-1:0]  word_reg, word_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic           wrap_reg, wrap_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  rover_reg, rover_next;
    logic           m_valid_reg;

    // transaction payload
    bpfa_pkg::kind_t kind_reg;
    logic [CW-1:0]   t_reg;
    logic            in_range_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   start_reg;
    logic [IW-1:0]   last_idx_reg;
    logic [IW-1:0]   hit_pos_reg;
    bpfa_pkg::out_item_t out_reg;

    // load-time decode
    logic [CW-1:0]  t_cur;
    logic [CW-1:0]  r_eff;
    logic [CW-1:0]  r_fin;
    logic [CW-1:0]  pos0;
    logic [XW-1:0]  addr_off;
    logic [XW-1:0]  pg_full;
    logic           range_cur;
    logic [IW-1:0]  fidx;

    // search
    logic [WB-1:0]  rdata;
    logic [WB-1:0]  lo_allow, hi_allow, cand;
    logic [WBL-1:0] enc;
    logic [AW-1:0]  start_word, last_word;
    logic           at_start, at_last;
    logic           hit;

    // memory port
    logic           ram_we;
    logic [WB-1:0]  ram_wdata;
    logic [WB-1:0]  fill_word;

    // result
    logic [XW-1:0]  grant;
    logic [CW-1:0]  free_cnt;
    logic           res_ok;

    bpfa_ram #(
        .WIDTH (WB),
        .DEPTH (NWORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (word_reg),
        .rdata (rdata)
    );

    always_comb begin
        t_cur = (32'(page_limit) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : page_limit;
        r_eff = (reserved_pages < t_cur) ? reserved_pages : t_cur;
        r_fin = (reserved_pages < t_reg) ? reserved_pages : t_reg;
        pos0  = (rover_reg < t_cur) ? rover_reg : '0;

        addr_off  = in_item.page_address - bpfa_pkg::BASE_ADDR;
        pg_full   = addr_off >> PBL;
        range_cur = (in_item.page_address >= bpfa_pkg::BASE_ADDR) && (pg_full < XW'(t_cur));
        fidx      = IW'(pg_full);
    end

    // word search: free bits inside [start, total) before the wrap, [0, total) after
    always_comb begin
        start_word = AW'(start_reg >> WBL);
        last_word  = AW'(last_idx_reg >> WBL);
        at_start   = (word_reg == start_word) && !wrap_reg;
        at_last    = (word_reg == last_word);
        for (int b = 0; b < WB; b++) begin
            lo_allow[b] = (WBL'(b) >= start_reg[WBL-1:0]);
            hi_allow[b] = (WBL'(b) <= last_idx_reg[WBL-1:0]);
            cand[b]     = !rdata[b] && (!at_last || hi_allow[b]) && (!at_start || lo_allow[b]);
        end
        enc = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (cand[b]) begin
                enc = WBL'(b);
            end
        end
        hit = (kind_reg == bpfa_pkg::KIND_FREE) ? rdata[idx_reg[WBL-1:0]] : |cand;
    end

    always_comb begin
        fill_word = (rem_reg >= CW'(WB)) ? '1 : ~({WB{1'b1}} << rem_reg[WBL-1:0]);
        ram_we    = cmd.wr || cmd.fill;
        if (cmd.fill) begin
            ram_wdata = fill_word;
        end else if (kind_reg == bpfa_pkg::KIND_ALLOC) begin
            ram_wdata = rdata | (WB'(1) << hit_pos_reg[WBL-1:0]);
        end else begin
            ram_wdata = rdata & ~(WB'(1) << idx_reg[WBL-1:0]);
        end
    end

    always_comb begin
        word_next = word_reg;
        rem_next  = rem_reg;
        wrap_next = wrap_reg;
        if (cmd.load) begin
            wrap_next = 1'b0;
            rem_next  = r_eff;
            case (in_item.kind)
                bpfa_pkg::KIND_FREE:  word_next = AW'(fidx >> WBL);
                bpfa_pkg::KIND_ALLOC: word_next = AW'(IW'(pos0) >> WBL);
                default:              word_next = '0;
            endcase
        end else if (cmd.step) begin
            if (at_last) begin
                word_next = '0;
                wrap_next = 1'b1;
            end else begin
                word_next = word_reg + AW'(1);
            end
        end else if (cmd.fill) begin
            word_next = (word_reg == AW'(NWORDS - 1)) ? '0 : word_reg + AW'(1);
            rem_next  = (rem_reg >= CW'(WB)) ? rem_reg - CW'(WB) : '0;
        end
    end

    // counter commit and result
    always_comb begin
        res_ok     = (cmd.res == bpfa_pkg::RES_OK);
        used_next  = used_reg;
        rover_next = rover_reg;
        if (res_ok) begin
            case (kind_reg)
                bpfa_pkg::KIND_ALLOC: begin
                    used_next  = used_reg + CW'(1);
                    rover_next = CW'(hit_pos_reg) + CW'(1);
                end
                bpfa_pkg::KIND_FREE: begin
                    used_next = used_reg - CW'(1);
                    if (CW'(idx_reg) < rover_reg) begin
                        rover_next = CW'(idx_reg);
                    end
                end
                bpfa_pkg::KIND_INIT: begin
                    used_next  = r_fin;
                    rover_next = r_fin;
                end
                default: begin
                    used_next = used_reg;
                end
            endcase
        end
        grant    = bpfa_pkg::BASE_ADDR + (XW'(hit_pos_reg) << PBL);
        free_cnt = (t_reg > used_next) ? t_reg - used_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg    <= '0;
            rem_reg     <= '0;
            wrap_reg    <= 1'b0;
            used_reg    <= '0;
            rover_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            word_reg <= word_next;
            rem_reg  <= rem_next;
            wrap_reg <= wrap_next;
            if (cmd.finish) begin
                used_reg    <= used_next;
                rover_reg   <= rover_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= in_item.kind;
            t_reg        <= t_cur;
            in_range_reg <= range_cur;
            idx_reg      <= fidx;
            start_reg    <= IW'(pos0);
            last_idx_reg <= IW'(t_cur - CW'(1));
        end
        if (cmd.latch_hit && kind_reg == bpfa_pkg::KIND_ALLOC) begin
            hit_pos_reg <= IW'({word_reg, enc});
        end
        if (cmd.finish) begin
            out_reg.ok              <= res_ok;
            out_reg.status          <= cmd.res;
            out_reg.granted_address <= (res_ok && kind_reg == bpfa_pkg::KIND_ALLOC) ? grant : '0;
            out_reg.used_count      <= used_next;
            out_reg.free_count      <= free_cnt;
        end
    end

    always_comb begin
        status           = '0;
        status.kind      = kind_reg;
        status.t_zero    = (t_reg == '0);
        status.in_range  = in_range_reg;
        status.hit       = hit;
        status.exhausted = wrap_reg && (word_reg == start_word);
        status.fill_last = (word_reg == AW'(NWORDS - 1));
        status.out_full  = m_valid_reg && !m_ready;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

`ifndef SYNTHESIS
    a_ok_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.ok == (out_reg.status == bpfa_pkg::RES_OK)))
        else $error("ok flag disagrees with status code");

    a_no_grant_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.ok) |-> (out_reg.granted_address == '0))
        else $error("address granted on a failed request");
`endif

endmodule

>>> hdl/bitmap_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// Next-fit page frame allocator over a used-bit map held in block RAM.
//
// One transaction is worked on at a time. The bitmap sits in a RAM of 32-bit
// words (4-bit words below 64 pages) and every access goes through its single
// registered read port, so each word visited by a search passes through a
// read state and then a check state. An allocate visits words from the rover
// word on and stops at the first free page; when the map is full or nearly so
// it may visit every word up to the page limit. A free reads one word and, if
// the page is in use, clears its bit; it is refused before any read when the
// address is out of range. An init sweeps every word of the map; a no-operation
// item goes straight to the result. After reset the block runs a clearing pass
// with s_ready low; configuration writes are taken throughout. The result
// register lets a new transaction be accepted while the previous result still
// waits on m_ready. Granted addresses are 0x1000000 + page * PAGE_BYTES;
// PAGE_BYTES must be a power of two. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core #(
    parameter int MAX_PAGES  = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bpfa_pkg::in_item_t                 s_payload,

    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output bpfa_pkg::out_item_t                m_payload,

    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpfa_pkg::CFG_W-1:0]         cfg_wdata
);

    // configuration registers
    logic [bpfa_pkg::CFG_W-1:0] page_limit_reg, page_limit_next;
    logic [bpfa_pkg::CFG_W-1:0] reserved_pages_reg, reserved_pages_next;

    // controller / datapath link
    bpfa_pkg::dp_cmd_t    dp_cmd;
    bpfa_pkg::dp_status_t dp_status;

    // register write decode
    always_comb begin
        page_limit_next     = page_limit_reg;
        reserved_pages_next = reserved_pages_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                bpfa_pkg::REG_PAGE_LIMIT:     page_limit_next     = cfg_wdata;
                bpfa_pkg::REG_RESERVED_PAGES: reserved_pages_next = cfg_wdata;
                default: begin
                    page_limit_next = page_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg     <= bpfa_pkg::PAGE_LIMIT_RST;
            reserved_pages_reg <= bpfa_pkg::RESERVED_PAGES_RST;
        end else begin
            page_limit_reg     <= page_limit_next;
            reserved_pages_reg <= reserved_pages_next;
        end
    end

    // sequencer: clearing pass, search loop, write-back, init sweep
    bpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_kind (s_payload.kind),
        .s_ready (s_ready),
        .cmd     (dp_cmd),
        .status  (dp_status)
    );

    // bitmap RAM, word search, counters and result register
    bpfa_dpath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .in_item        (s_payload),
        .page_limit     (page_limit_reg),
        .reserved_pages (reserved_pages_reg),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_payload      (m_payload)
    );

endmodule
